// ----- design/gcr_pkg.sv -----
package gcr_pkg;

    localparam int SYNC_BYTES_DEF = 5;
    localparam int GAP_BYTES_DEF  = 9;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] HDR_MARK      = 8'h08;
    localparam logic [7:0] HDR_MARK_BAD  = 8'hff;
    localparam logic [7:0] DATA_MARK     = 8'h07;
    localparam logic [7:0] DATA_MARK_BAD = 8'h00;
    localparam logic [7:0] HDR_PAD       = 8'h0f;
    localparam logic [7:0] GAP_FILL      = 8'h55;
    localparam logic [7:0] SYNC_FILL     = 8'hff;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;

    localparam logic CFG_ID_FIRST  = 1'b0;
    localparam logic CFG_ID_SECOND = 1'b1;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_NO_HEADER = 3'd1,
        ERR_NO_SYNC   = 3'd2,
        ERR_NO_BLOCK  = 3'd3,
        ERR_DATA_CHK  = 3'd4,
        ERR_HDR_CHK   = 3'd5,
        ERR_ID_MISM   = 3'd6,
        ERR_UNUSED    = 3'd7
    } t_err;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC1,
        PH_HGRP0,
        PH_HGRP1,
        PH_GAP,
        PH_SYNC2,
        PH_DATA
    } t_phase;

    // one queued command: either a full header burst or one data group
    typedef struct packed {
        logic        is_hdr;
        logic        last;
        logic [7:0]  sync;
        logic [31:0] grp0;   // first byte in the top bits
        logic [31:0] grp1;
    } t_cmd;

    function automatic logic [4:0] gcr_nib(input logic [3:0] n);
        logic [4:0] r;
        unique case (n)
            4'h0: r = 5'h0a;
            4'h1: r = 5'h0b;
            4'h2: r = 5'h12;
            4'h3: r = 5'h13;
            4'h4: r = 5'h0e;
            4'h5: r = 5'h0f;
            4'h6: r = 5'h16;
            4'h7: r = 5'h17;
            4'h8: r = 5'h09;
            4'h9: r = 5'h19;
            4'ha: r = 5'h1a;
            4'hb: r = 5'h1b;
            4'hc: r = 5'h0d;
            4'hd: r = 5'h1d;
            4'he: r = 5'h1e;
            default: r = 5'h15;
        endcase
        return r;
    endfunction

    function automatic logic [39:0] gcr_encode(input logic [31:0] g);
        logic [39:0] r;
        for (int i = 0; i < 8; i++) begin
            r[5*i +: 5] = gcr_nib(g[4*i +: 4]);
        end
        return r;
    endfunction

endpackage

// ----- design/gcr_front.sv -----
module gcr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_index,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data,
    input  logic [7:0]    i_track,
    input  logic [7:0]    i_sector,
    input  logic [2:0]    i_err,
    input  logic          i_q_full,
    output logic          o_push,
    output gcr_pkg::t_cmd o_cmd
);

    logic [7:0]  r_id_first, r_id_second;
    logic [7:0]  r_pos, n_pos;
    logic [23:0] r_buf, n_buf;
    logic [7:0]  r_chk, n_chk;
    logic [1:0]  r_fill, n_fill;
    logic        w_acc;
    logic [7:0]  w_sync, w_idm, w_hchk, w_mark;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;

    assign w_sync = (i_err == gcr_pkg::ERR_NO_SYNC)   ? gcr_pkg::GAP_FILL : gcr_pkg::SYNC_FILL;
    assign w_idm  = (i_err == gcr_pkg::ERR_ID_MISM)   ? 8'hff : 8'h00;
    assign w_mark = (i_err == gcr_pkg::ERR_NO_HEADER) ? gcr_pkg::HDR_MARK_BAD
                                                      : gcr_pkg::HDR_MARK;
    assign w_hchk = ((i_err == gcr_pkg::ERR_HDR_CHK) ? 8'hff : 8'h00)
                    ^ i_sector ^ i_track ^ r_id_first ^ r_id_second ^ w_idm;

    always_comb begin
        n_pos  = r_pos;
        n_buf  = r_buf;
        n_chk  = r_chk;
        n_fill = r_fill;
        o_push = 1'b0;
        o_cmd  = '0;
        if (w_acc) begin
            priority if (r_pos == 8'd0) begin
                o_push      = 1'b1;
                o_cmd.is_hdr = 1'b1;
                o_cmd.sync  = w_sync;
                o_cmd.grp0  = {w_mark, w_hchk, i_sector, i_track};
                o_cmd.grp1  = {r_id_second, r_id_first ^ w_idm,
                               gcr_pkg::HDR_PAD, gcr_pkg::HDR_PAD};
                n_chk  = ((i_err == gcr_pkg::ERR_DATA_CHK) ? 8'hff : 8'h00) ^ i_data;
                n_buf  = {8'h00,
                          (i_err == gcr_pkg::ERR_NO_BLOCK) ? gcr_pkg::DATA_MARK_BAD
                                                           : gcr_pkg::DATA_MARK,
                          i_data};
                n_fill = 2'd2;
                n_pos  = 8'd1;
            end else if (r_pos == 8'd255) begin
                o_push     = 1'b1;
                o_cmd.last = 1'b1;
                o_cmd.grp0 = {i_data, r_chk ^ i_data, gcr_pkg::ZERO_BYTE, gcr_pkg::ZERO_BYTE};
                n_chk  = 8'd0;
                n_buf  = 24'd0;
                n_fill = 2'd0;
                n_pos  = 8'd0;
            end else begin
                n_chk = r_chk ^ i_data;
                n_pos = r_pos + 8'd1;
                if (r_fill == 2'd3) begin
                    o_push     = 1'b1;
                    o_cmd.grp0 = {r_buf, i_data};
                    n_buf  = 24'd0;
                    n_fill = 2'd0;
                end else begin
                    n_buf  = {r_buf[15:0], i_data};
                    n_fill = r_fill + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_first  <= 8'd0;
            r_id_second <= 8'd0;
            r_pos       <= 8'd0;
            r_buf       <= 24'd0;
            r_chk       <= 8'd0;
            r_fill      <= 2'd0;
        end else begin
            r_pos  <= n_pos;
            r_buf  <= n_buf;
            r_chk  <= n_chk;
            r_fill <= n_fill;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    gcr_pkg::CFG_ID_FIRST:  r_id_first  <= i_cfg_wdata;
                    gcr_pkg::CFG_ID_SECOND: r_id_second <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- design/gcr_queue.sv -----
module gcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gcr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output gcr_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = gcr_pkg::QUEUE_PTR_W;

    gcr_pkg::t_cmd r_mem [gcr_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(gcr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/gcr_back.sv -----
module gcr_back #(
    parameter int SYNC_BYTES = gcr_pkg::SYNC_BYTES_DEF,
    parameter int GAP_BYTES  = gcr_pkg::GAP_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  gcr_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last
);

    localparam int MAXC  = (SYNC_BYTES > GAP_BYTES) ?
                           ((SYNC_BYTES > 5) ? SYNC_BYTES : 5) :
                           ((GAP_BYTES > 5) ? GAP_BYTES : 5);
    localparam int CW    = $clog2(MAXC);
    localparam int GAP_L = (GAP_BYTES > 0) ? GAP_BYTES - 1 : 0;

    gcr_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [39:0]     r_sh, n_sh;
    logic [39:0]     r_hdr2;
    logic [7:0]      r_sync;
    logic            r_end;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_last;
    logic            w_adv;
    logic            w_cnt_sync, w_cnt_grp, w_cnt_gap;
    logic [7:0]      w_byte;
    logic            w_last;

    assign w_adv      = (r_phase != gcr_pkg::PH_IDLE) && (!r_out_valid || i_ready);
    assign o_pop      = (r_phase == gcr_pkg::PH_IDLE) && !i_q_empty;
    assign w_cnt_sync = (r_cnt == CW'(SYNC_BYTES - 1));
    assign w_cnt_grp  = (r_cnt == CW'(4));
    assign w_cnt_gap  = (r_cnt == CW'(GAP_L));

    // next phase
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_sh    = r_sh;
        if (o_pop) begin
            n_cnt   = '0;
            n_sh    = gcr_pkg::gcr_encode(i_cmd.grp0);
            n_phase = i_cmd.is_hdr ? gcr_pkg::PH_SYNC1 : gcr_pkg::PH_DATA;
        end else if (w_adv) begin
            n_cnt = r_cnt + CW'(1);
            unique case (r_phase)
                gcr_pkg::PH_SYNC1: begin
                    if (w_cnt_sync) begin
                        n_phase = gcr_pkg::PH_HGRP0;
                        n_cnt   = '0;
                    end
                end
                gcr_pkg::PH_HGRP0: begin
                    n_sh = {r_sh[31:0], 8'h00};
                    if (w_cnt_grp) begin
                        n_phase = gcr_pkg::PH_HGRP1;
                        n_cnt   = '0;
                        n_sh    = r_hdr2;
                    end
                end
                gcr_pkg::PH_HGRP1: begin
                    n_sh = {r_sh[31:0], 8'h00};
                    if (w_cnt_grp) begin
                        n_phase = (GAP_BYTES > 0) ? gcr_pkg::PH_GAP : gcr_pkg::PH_SYNC2;
                        n_cnt   = '0;
                    end
                end
                gcr_pkg::PH_GAP: begin
                    if (w_cnt_gap) begin
                        n_phase = gcr_pkg::PH_SYNC2;
                        n_cnt   = '0;
                    end
                end
                gcr_pkg::PH_SYNC2: begin
                    if (w_cnt_sync) begin
                        n_phase = gcr_pkg::PH_IDLE;
                    end
                end
                gcr_pkg::PH_DATA: begin
                    n_sh = {r_sh[31:0], 8'h00};
                    if (w_cnt_grp) begin
                        n_phase = gcr_pkg::PH_IDLE;
                    end
                end
                default: n_phase = gcr_pkg::PH_IDLE;
            endcase
        end
    end

    // emitted byte
    always_comb begin
        w_byte = r_sh[39:32];
        w_last = 1'b0;
        unique case (r_phase)
            gcr_pkg::PH_SYNC1, gcr_pkg::PH_SYNC2: w_byte = r_sync;
            gcr_pkg::PH_GAP:                      w_byte = gcr_pkg::GAP_FILL;
            gcr_pkg::PH_DATA:                     w_last = r_end && w_cnt_grp;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= gcr_pkg::PH_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh <= n_sh;
        if (o_pop) begin
            r_hdr2 <= gcr_pkg::gcr_encode(i_cmd.grp1);
            r_sync <= i_cmd.sync;
            r_end  <= i_cmd.last;
        end
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

// ----- design/gcr_sector_encoder.sv -----
// GCR sector encoder.
// Input stream s_axis: one raw sector byte per item, 256 items per sector.
// Track, sector and error code are used only with the first byte of a sector.
// Output stream m_axis: encoded bytes, MSB first; tlast marks the final byte
// of a sector. Disk ID bytes must be written by the user through the cfg port
// while idle; the block does not enforce this. The first byte of a sector
// produces the header burst of 2*SYNC_BYTES + GAP_BYTES + 10 bytes; every
// completed four byte group then produces five bytes, the last group carrying
// the data checksum. The first output byte of a command passes through the
// command queue, the sequencer registers and the output register.
// Throughput: one input item per cycle while the four entry command queue
// has room; the output sequencer gives one byte per cycle within a command
// while the receiver is ready, and emits no byte in the step in which it
// loads the next command from the queue.
// A stalled receiver holds the output register; the sequencer stops, the
// queue fills and s_axis_tready drops. Reset clears the sector position,
// checksum, queue and sequencer; disk IDs return to zero.
module gcr_sector_encoder #(
    parameter int SYNC_BYTES = gcr_pkg::SYNC_BYTES_DEF,
    parameter int GAP_BYTES  = gcr_pkg::GAP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_byte, track_number, sector_number, error_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // gcr_byte
    output logic        m_axis_tlast
);

    gcr_pkg::t_cmd w_push_cmd, w_pop_cmd;
    logic          w_push, w_pop, w_full, w_empty;

    gcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata[7:0]),
        .i_track     (s_axis_tdata[15:8]),
        .i_sector    (s_axis_tdata[23:16]),
        .i_err       (s_axis_tdata[26:24]),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    gcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    gcr_back #(
        .SYNC_BYTES (SYNC_BYTES),
        .GAP_BYTES  (GAP_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_cmd     (w_pop_cmd),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule
